// ----- hw/rtl/blist_pkg.sv -----
// Shared types, codes and widths for the bounded array list.
`default_nettype none

package blist_pkg;

    // Defaults for the top-level parameters
    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Index and count width large enough for the largest supported capacity
    localparam int IDX_W = 11;

    // Fixed field widths
    localparam int MODE_W   = 4;
    localparam int POS_W    = 6;
    localparam int VALUE_W  = 32;
    localparam int RDVAL_W  = 32;
    localparam int OUTCNT_W = 7;

    localparam int S_TDATA_W = 40;   // position + value, padded to bytes
    localparam int M_TDATA_W = 56;   // 49 result bits, padded to bytes

    // Operation codes carried in tuser
    localparam logic [MODE_W-1:0] MODE_INS_FRONT = 4'd0;
    localparam logic [MODE_W-1:0] MODE_INS_BACK  = 4'd1;
    localparam logic [MODE_W-1:0] MODE_INS_AT    = 4'd2;
    localparam logic [MODE_W-1:0] MODE_REM_FRONT = 4'd3;
    localparam logic [MODE_W-1:0] MODE_REM_BACK  = 4'd4;
    localparam logic [MODE_W-1:0] MODE_REM_AT    = 4'd5;
    localparam logic [MODE_W-1:0] MODE_SEARCH    = 4'd6;
    localparam logic [MODE_W-1:0] MODE_SELECT    = 4'd7;
    localparam logic [MODE_W-1:0] MODE_REPLACE   = 4'd8;

    // Per-cell action broadcast along the chain
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_WRITE  = 2'd3
    } cell_op_t;

    // lo: target index (insert/remove/write/select), hi: current count
    typedef struct packed {
        cell_op_t           op;
        logic [IDX_W-1:0]   lo;
        logic [IDX_W-1:0]   hi;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bounded_array_list.sv -----
// Top level of the bounded array list: request control, cell chain, result register.
// A request is taken into the request registers; in the execute state the cell chain
// is updated and the result is collected into the output register, from which it leaves.
// The chain takes a new request only when idle, not before the last one is through,
// and a result waiting on m_tready holds the next request in its execute state.
// Reset (rst_n low, asynchronous): count cleared, control idle, no result pending;
// entry contents are not cleared and are never read above the count.
`default_nettype none

module bounded_array_list #(
    parameter int CAPACITY   = blist_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = blist_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // slave side: tdata from bit 0 = position[5:0], value[31:0], 2 pad bits
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [blist_pkg::S_TDATA_W-1:0]  s_tdata,
    // tuser = mode[3:0]
    input  wire logic [blist_pkg::MODE_W-1:0]     s_tuser,
    // master side: tdata from bit 0 = ok, read_value[31:0], found_index[6:0],
    // count[6:0], is_empty, is_full, 7 pad bits
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [blist_pkg::M_TDATA_W-1:0]  m_tdata
);
    import blist_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] CAP_IDX = IDX_W'(CAPACITY);

    // one-hot control states
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    logic [MODE_W-1:0]     mode_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  m_valid_reg;
    logic [M_TDATA_W-1:0]  m_data_reg, m_data_next;

    logic s_fire;
    logic fire;    // execute cycle whose result the output register can take

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign fire     = (state_reg == S_EXEC) && (!m_valid_reg || m_tready);

    // ---------------------------------------------------------------
    // request decode: builds the broadcast for the cell chain
    // ---------------------------------------------------------------
    cell_ctl_t        ctl;
    cell_op_t         op_c;
    logic [IDX_W-1:0] lo_c;
    logic [IDX_W-1:0] cnt_x;
    logic [IDX_W-1:0] pos_x;
    logic             list_full;
    logic             list_empty;
    logic             ok_c;
    logic [IDX_W-1:0] found_c;
    logic [DATA_WIDTH-1:0] rd_c;

    logic [IDX_W-1:0]      enc_idx;
    logic                  any_match;
    logic [DATA_WIDTH-1:0] read_word;

    assign cnt_x      = IDX_W'(count_reg);
    assign pos_x      = IDX_W'(pos_reg);
    assign list_full  = (cnt_x == CAP_IDX);
    assign list_empty = (count_reg == '0);

    always_comb
    begin
        op_c       = CELL_HOLD;
        lo_c       = '0;
        ok_c       = 1'b0;
        found_c    = '0;
        rd_c       = '0;
        count_next = count_reg;
        unique case (mode_reg)
            MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AT:
            begin
                if (mode_reg == MODE_INS_BACK)
                begin
                    lo_c = cnt_x;
                end
                else if (mode_reg == MODE_INS_AT)
                begin
                    lo_c = pos_x;
                end
                if (!list_full && lo_c <= cnt_x)
                begin
                    ok_c       = 1'b1;
                    op_c       = CELL_INSERT;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            MODE_REM_FRONT, MODE_REM_AT:
            begin
                if (mode_reg == MODE_REM_AT)
                begin
                    lo_c = pos_x;
                end
                if (lo_c < cnt_x)
                begin
                    ok_c       = 1'b1;
                    op_c       = CELL_REMOVE;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            MODE_REM_BACK:
            begin
                // tail entry is simply dropped by the count
                if (!list_empty)
                begin
                    ok_c       = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            MODE_SEARCH:
            begin
                ok_c    = any_match;
                found_c = enc_idx;
            end
            MODE_SELECT:
            begin
                // past the end reads the last entry
                lo_c = (pos_x < cnt_x) ? pos_x : (cnt_x - IDX_W'(1));
                if (!list_empty)
                begin
                    ok_c = 1'b1;
                    rd_c = read_word;
                end
            end
            MODE_REPLACE:
            begin
                lo_c = pos_x;
                if (pos_x < cnt_x)
                begin
                    ok_c = 1'b1;
                    op_c = CELL_WRITE;
                end
            end
            default:
            begin
                op_c = CELL_HOLD;
            end
        endcase
    end

    assign ctl.op = fire ? op_c : CELL_HOLD;
    assign ctl.lo = lo_c;
    assign ctl.hi = cnt_x;

    // ---------------------------------------------------------------
    // cell chain
    // ---------------------------------------------------------------
    logic [CAPACITY-1:0][DATA_WIDTH-1:0] cell_data;
    logic [CAPACITY-1:0][DATA_WIDTH-1:0] cell_hit;
    logic [CAPACITY-1:0]                 cell_match;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_w;
        logic [DATA_WIDTH-1:0] right_w;

        if (g == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = cell_data[g+1];
        end

        blist_cell #(
            .INDEX      (g),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .value_in   (value_reg),
            .left_data  (left_w),
            .right_data (right_w),
            .data_out   (cell_data[g]),
            .match      (cell_match[g]),
            .hit_data   (cell_hit[g])
        );
    end

    blist_collect #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_collect (
        .match      (cell_match),
        .hit_data   (cell_hit),
        .miss_idx   (cnt_x),
        .found_idx  (enc_idx),
        .any_match  (any_match),
        .read_word  (read_word)
    );

    // ---------------------------------------------------------------
    // result packing
    // ---------------------------------------------------------------
    logic [CNT_W-1:0] cnt_after;
    assign cnt_after = count_next;

    always_comb
    begin
        m_data_next = '0;
        m_data_next[0]     = ok_c;
        m_data_next[32:1]  = RDVAL_W'(rd_c);
        m_data_next[39:33] = OUTCNT_W'(found_c);
        m_data_next[46:40] = OUTCNT_W'(cnt_after);
        m_data_next[47]    = (cnt_after == '0);
        m_data_next[48]    = (IDX_W'(cnt_after) == CAP_IDX);
    end

    // ---------------------------------------------------------------
    // control
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fire)
            begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // request and result payload, no reset
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            mode_reg  <= s_tuser;
            pos_reg   <= s_tdata[POS_W-1:0];
            value_reg <= DATA_WIDTH'(s_tdata[POS_W+VALUE_W-1:POS_W]);
        end
        if (fire)
        begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/blist_cell.sv -----
// One list slot: holds an entry, shifts with its neighbors, compares and selects.
`default_nettype none

module blist_cell #(
    parameter int INDEX      = 0,
    parameter int DATA_WIDTH = blist_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire blist_pkg::cell_ctl_t  ctl,
    input  wire logic [DATA_WIDTH-1:0] value_in,
    input  wire logic [DATA_WIDTH-1:0] left_data,   // from slot INDEX-1
    input  wire logic [DATA_WIDTH-1:0] right_data,  // from slot INDEX+1
    output logic      [DATA_WIDTH-1:0] data_out,
    output logic                       match,
    output logic      [DATA_WIDTH-1:0] hit_data
);
    import blist_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(INDEX);
    localparam logic [IDX_W:0]   NEXT_IDX = (IDX_W+1)'(INDEX + 1);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (ctl.op)
            CELL_INSERT:
            begin
                if (MY_IDX == ctl.lo)
                begin
                    data_next = value_in;
                end
                else if (MY_IDX > ctl.lo && MY_IDX <= ctl.hi)
                begin
                    data_next = left_data;
                end
            end
            CELL_REMOVE:
            begin
                if (MY_IDX >= ctl.lo && NEXT_IDX < {1'b0, ctl.hi})
                begin
                    data_next = right_data;
                end
            end
            CELL_WRITE:
            begin
                if (MY_IDX == ctl.lo)
                begin
                    data_next = value_in;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;
    assign match    = (MY_IDX < ctl.hi) && (data_reg == value_in);
    assign hit_data = (MY_IDX == ctl.lo) ? data_reg : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/blist_collect.sv -----
// Gathers cell outputs: lowest matching index and the selected entry.
`default_nettype none

module blist_collect #(
    parameter int CAPACITY   = blist_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = blist_pkg::DATA_WIDTH_DEF
) (
    input  wire logic [CAPACITY-1:0]             match,
    input  wire logic [CAPACITY-1:0][DATA_WIDTH-1:0] hit_data,
    input  wire logic [blist_pkg::IDX_W-1:0]     miss_idx,
    output logic      [blist_pkg::IDX_W-1:0]     found_idx,
    output logic                                 any_match,
    output logic      [DATA_WIDTH-1:0]           read_word
);
    import blist_pkg::*;

    // priority encoder, lowest index wins
    always_comb
    begin
        found_idx = miss_idx;
        any_match = 1'b0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                found_idx = IDX_W'(i);
                any_match = 1'b1;
            end
        end
    end

    // at most one cell drives a nonzero hit word
    always_comb
    begin
        read_word = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            read_word = read_word | hit_data[i];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/blist_checker.sv -----
// Port-level checks for the bounded array list, bound to the top level.
`default_nettype none

module blist_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [blist_pkg::M_TDATA_W-1:0]  m_tdata
);
    import blist_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // after an accepted request, m_tvalid is high past its execute state (its result or a stalled one)
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> ##1 m_tvalid)
        else $error("no result after request");

    // no read data without success
    a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[32:1] == 32'd0)
        else $error("read_value set on failed request");

    // empty means zero count, and never both empty and full
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[47] |-> m_tdata[46:40] == 7'd0 && !m_tdata[48])
        else $error("inconsistent empty flag");

endmodule

bind bounded_array_list blist_checker u_blist_checker (.*);

`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for bounded_array_list: directed and random requests.
`timescale 1ns / 100ps

module tb_top;
    import blist_pkg::*;

    localparam int LIST_CAP        = CAPACITY_DEF;
    localparam int RESET_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT  = 1000;   // cycles with no transfer on either side
    localparam int DRAIN_CYCLES    = 10;     // margin after the last expected result
    localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = 4'd9;
    localparam logic [MODE_W-1:0] MODE_UNUSED_LAST  = 4'd15;

    // one result as it travels on m_tdata, lowest field last
    typedef struct packed {
        logic                is_full;
        logic                is_empty;
        logic [OUTCNT_W-1:0] count;
        logic [OUTCNT_W-1:0] found_index;
        logic [RDVAL_W-1:0]  read_value;
        logic                ok;
    } list_result_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [MODE_W-1:0]    s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    // shadow copy of the list, updated when a request is accepted
    logic [VALUE_W-1:0] list_words [LIST_CAP];
    int                 list_len;

    list_result_t expected_results [$];
    int           error_count;
    bit           idle_en;        // random gaps on both sides
    int           stall_left;

    bounded_array_list i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // position[5:0], value[31:0], 2 pad bits
        .s_tuser  (s_tuser),    // mode[3:0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)     // ok, read_value, found_index, count, is_empty, is_full
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // List behavior
    // ------------------------------------------------------------------

    // Insert: later entries move up one slot.
    function automatic logic put_word(int at, logic [VALUE_W-1:0] word);
        if (list_len >= LIST_CAP || at > list_len)
            return 1'b0;
        for (int i = list_len; i > at; i--)
            list_words[i] = list_words[i-1];
        list_words[at] = word;
        list_len++;
        return 1'b1;
    endfunction

    // Remove: later entries move down one slot.
    function automatic logic take_word(int at);
        if (list_len == 0 || at >= list_len)
            return 1'b0;
        for (int i = at; i + 1 < list_len; i++)
            list_words[i] = list_words[i+1];
        list_len--;
        return 1'b1;
    endfunction

    function automatic list_result_t apply_request(logic [MODE_W-1:0] mode,
                                                   logic [POS_W-1:0] pos,
                                                   logic [VALUE_W-1:0] word);
        list_result_t res;
        res = '0;
        case (mode)
            MODE_INS_FRONT: res.ok = put_word(0, word);
            MODE_INS_BACK:  res.ok = put_word(list_len, word);
            MODE_INS_AT:    res.ok = put_word(int'(pos), word);
            MODE_REM_FRONT: res.ok = take_word(0);
            MODE_REM_BACK:
            begin
                if (list_len != 0)
                begin
                    list_len--;
                    res.ok = 1'b1;
                end
            end
            MODE_REM_AT:    res.ok = take_word(int'(pos));
            MODE_SEARCH:
            begin
                // lowest match wins; a miss reports the count
                res.found_index = OUTCNT_W'(list_len);
                for (int i = 0; i < list_len; i++)
                begin
                    if (list_words[i] == word)
                    begin
                        res.found_index = OUTCNT_W'(i);
                        res.ok          = 1'b1;
                        break;
                    end
                end
            end
            MODE_SELECT:
            begin
                // past the end reads the last entry
                if (list_len != 0)
                begin
                    res.read_value = (int'(pos) < list_len) ? list_words[pos]
                                                            : list_words[list_len-1];
                    res.ok         = 1'b1;
                end
            end
            MODE_REPLACE:
            begin
                if (int'(pos) < list_len)
                begin
                    list_words[pos] = word;
                    res.ok          = 1'b1;
                end
            end
            default: ;  // unused codes leave the list alone
        endcase
        res.count    = OUTCNT_W'(list_len);
        res.is_empty = (list_len == 0);
        res.is_full  = (list_len == LIST_CAP);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------

    // Drives one request at the falling edge and holds it until accepted.
    // tvalid is lowered only inside a gap, so it never toggles within one step.
    task automatic send_request(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
                                logic [VALUE_W-1:0] word);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 15);
            repeat (gap)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {2'b00, word, pos};
        do
            @(posedge clk);
        while (!s_tready);
        expected_results.push_back(apply_request(mode, pos, word));
    endtask

    // Random request shaped by the current fill level. Weights in percent:
    // ins_w inserts, rem_w removes, 2 unused codes, the rest search/select/replace.
    task automatic send_random(int ins_w, int rem_w);
        logic [MODE_W-1:0]  mode;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] word;
        int                 pick;
        pick = $urandom_range(0, 99);
        if (pick < ins_w)
            mode = MODE_INS_FRONT + MODE_W'($urandom_range(0, 2));
        else if (pick < ins_w + rem_w)
            mode = MODE_REM_FRONT + MODE_W'($urandom_range(0, 2));
        else if (pick < 98)
            mode = MODE_SEARCH + MODE_W'($urandom_range(0, 2));
        else
            mode = MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));

        // mostly near the valid range, including one past the end
        if ($urandom_range(0, 4) != 0)
            pos = POS_W'($urandom_range(0, (list_len > 63) ? 63 : list_len));
        else
            pos = POS_W'($urandom_range(0, 63));

        // reuse stored words so searches hit and duplicates appear
        pick = $urandom_range(0, 11);
        if (pick < 4 && list_len > 0)
            word = list_words[$urandom_range(0, list_len - 1)];
        else if (pick < 6)
            word = VALUE_W'($urandom_range(0, 7));
        else if (pick == 6)
            word = '1;
        else
            word = $urandom;
        send_request(mode, pos, word);
    endtask

    // ------------------------------------------------------------------
    // Result side: ready bursts and checking
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (idle_en && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 14);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        list_result_t want;
        list_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = list_result_t'(m_tdata[$bits(list_result_t)-1:0]);
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual 0x%0h",
                         $time, got);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("ok",          want.ok,          got.ok);
                check_field("read_value",  want.read_value,  got.read_value);
                check_field("found_index", want.found_index, got.found_index);
                check_field("count",       want.count,       got.count);
                check_field("is_empty",    want.is_empty,    got.is_empty);
                check_field("is_full",     want.is_full,     got.is_full);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every remove, replace, select and search on an empty list, and an insert above the count.
    task automatic test_empty_list();
        send_request(MODE_REM_FRONT, 6'd0,  32'h0000_0000);
        send_request(MODE_REM_BACK,  6'd0,  32'h0000_0000);
        send_request(MODE_REM_AT,    6'd0,  32'h0000_0000);
        send_request(MODE_REPLACE,   6'd0,  32'h1234_5678);
        send_request(MODE_SELECT,    6'd0,  32'h0000_0000);
        send_request(MODE_SEARCH,    6'd0,  32'h0000_0000);
        send_request(MODE_INS_AT,    6'd1,  32'hDEAD_BEEF);  // index above count
    endtask

    // Inserts, replaces and removes at the edges of the index range.
    task automatic test_index_bounds();
        send_request(MODE_INS_BACK,  6'd63, 32'hFFFF_FFFF);
        send_request(MODE_INS_FRONT, 6'd0,  32'h0000_0000);
        send_request(MODE_INS_AT,    6'd1,  32'h8000_0001);
        send_request(MODE_INS_AT,    6'd4,  32'h5555_5555);  // above count
        send_request(MODE_INS_AT,    6'd3,  32'hAAAA_AAAA);  // at count: append
        send_request(MODE_REPLACE,   6'd4,  32'h0F0F_0F0F);  // at count: fails
        send_request(MODE_REPLACE,   6'd2,  32'hA5A5_A5A5);
        send_request(MODE_REM_AT,    6'd63, 32'h0000_0000);
    endtask

    // Search hit and miss; select in range and past the end.
    task automatic test_search_select();
        send_request(MODE_INS_BACK,  6'd0,  32'hFFFF_FFFF);  // word not otherwise in the list
        send_request(MODE_SEARCH,    6'd0,  32'hFFFF_FFFF);
        send_request(MODE_SEARCH,    6'd0,  32'h1234_5678);
        send_request(MODE_SELECT,    6'd1,  32'h0000_0000);
        send_request(MODE_SELECT,    6'd63, 32'h0000_0000);
        send_request(MODE_REM_AT,    6'd1,  32'h0000_0000);
    endtask

    task automatic test_unused_modes();
        send_request(MODE_UNUSED_FIRST, 6'd0,  32'hFFFF_FFFF);
        send_request(MODE_UNUSED_LAST,  6'd63, 32'h0000_0000);
        send_request(MODE_REM_BACK,     6'd0,  32'h0000_0000);
        send_request(MODE_REM_FRONT,    6'd0,  32'h0000_0000);
    endtask

    // Fill to capacity and linger there, then drain to empty and linger.
    task automatic test_fill_drain();
        int sent;
        int lingered;
        sent     = 0;
        lingered = 0;
        while (lingered < 40 && sent < 400)
        begin
            send_random(70, 10);
            sent++;
            if (list_len == LIST_CAP)
                lingered++;
        end
        sent     = 0;
        lingered = 0;
        while (lingered < 20 && sent < 400)
        begin
            send_random(10, 70);
            sent++;
            if (list_len == 0)
                lingered++;
        end
    endtask

    task automatic test_random_mix(int items);
        repeat (items)
            send_random(36, 30);
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        m_tready    = 1'b0;
        stall_left  = 0;
        error_count = 0;
        list_len    = 0;
        idle_en     = 1'b1;
        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_index_bounds();
        test_search_select();
        test_unused_modes();
        test_fill_drain();
        test_random_mix(300);
        idle_en = 1'b0;   // closing stretch runs back to back
        test_random_mix(140);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (error_count == 0)
            $display("bounded_array_list regression: pass");
        else
            $display("bounded_array_list regression: fail");
        $finish;
    end

    // Ends a hung run: counts cycles in which neither side transfers.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("bounded_array_list regression: fail");
        $finish;
    end

endmodule
